@@ hdl/b64sc_pkg.sv @@
// Shared types, constants and character mapping functions for the base64 stream codec.
// No dependencies; every other file in hdl/ uses this package by scoped names.
package b64sc_pkg;

    // Most results that one input word can cause
    localparam int MAX_RESULTS = 4;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS);

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_PAD   = 8'd61;   // '='
    localparam logic [7:0] CHAR_PLUS  = 8'd43;   // '+'
    localparam logic [7:0] CHAR_SLASH = 8'd47;   // '/'
    localparam logic [7:0] CHAR_UC_A  = 8'd65;   // 'A'
    localparam logic [7:0] CHAR_UC_Z  = 8'd90;   // 'Z'
    localparam logic [7:0] CHAR_LC_A  = 8'd97;   // 'a'
    localparam logic [7:0] CHAR_LC_Z  = 8'd122;  // 'z'
    localparam logic [7:0] CHAR_ZERO  = 8'd48;   // '0'
    localparam logic [7:0] CHAR_NINE  = 8'd57;   // '9'

    // Input word
    typedef struct packed {
        logic [7:0] in_value;
        logic       message_last;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic [7:0] out_value;
        logic       has_data;
        logic       message_end;
        logic       run_last;
    } out_item_t;

    // Codec state carried between words
    typedef struct packed {
        logic [15:0] acc;
        logic [3:0]  pending;
        logic [1:0]  cmod;
        logic        stopped;
    } codec_state_t;

    // Group of results produced by one input word
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] res;
        logic [COUNT_W-1:0]          count;
    } result_group_t;

    // Decoded character: ok is low for anything outside the alphabet
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    // Six-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26)
            c = CHAR_UC_A + {2'b00, s};
        else if (s < 6'd52)
            c = CHAR_LC_A - 8'd26 + {2'b00, s};
        else if (s < 6'd62)
            c = CHAR_ZERO - 8'd52 + {2'b00, s};
        else if (s == 6'd62)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

    // Alphabet character to six-bit value
    function automatic sextet_t dec_char(input logic [7:0] ch);
        sextet_t d;
        logic [7:0] t;
        d = '0;
        t = '0;
        if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
            t = ch - CHAR_UC_A;
            d = '{ok: 1'b1, val: t[5:0]};
        end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
            t = ch - CHAR_LC_A + 8'd26;
            d = '{ok: 1'b1, val: t[5:0]};
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            t = ch - CHAR_ZERO + 8'd52;
            d = '{ok: 1'b1, val: t[5:0]};
        end else if (ch == CHAR_PLUS) begin
            d = '{ok: 1'b1, val: 6'd62};
        end else if (ch == CHAR_SLASH) begin
            d = '{ok: 1'b1, val: 6'd63};
        end
        return d;
    endfunction

endpackage

@@ hdl/b64sc_calc.sv @@
// Single-pass encode/decode logic: one input word plus codec state to a result group.
// Depends on b64sc_pkg (types, alphabet functions).
module b64sc_calc (
    input  logic                    dir,
    input  b64sc_pkg::in_item_t     item,
    input  b64sc_pkg::codec_state_t st,
    output b64sc_pkg::codec_state_t st_next,
    output b64sc_pkg::result_group_t grp
);

    b64sc_pkg::out_item_t [b64sc_pkg::MAX_RESULTS-1:0] res;
    logic [b64sc_pkg::COUNT_W-1:0] n;
    logic [b64sc_pkg::SLOT_W-1:0]  last_slot;
    logic [15:0] acc_n;
    logic [15:0] sh;
    logic [4:0]  pend;
    logic [1:0]  cm;
    logic        stop;
    b64sc_pkg::sextet_t dch;

    // Work out every result of the word in one pass
    always_comb
    begin
        res       = '0;
        n         = '0;
        last_slot = '0;
        acc_n     = st.acc;
        pend      = {1'b0, st.pending};
        cm        = st.cmod;
        stop      = st.stopped;
        sh        = '0;
        dch       = '0;

        if (dir == b64sc_pkg::DIR_ENCODE)
        begin
            acc_n = {st.acc[7:0], item.in_value};
            pend  = pend + 5'd8;
            // at most two full characters per byte
            for (int k = 0; k < 2; k++)
            begin
                if (pend >= 5'd6)
                begin
                    pend = pend - 5'd6;
                    sh   = acc_n >> pend;
                    if (n < b64sc_pkg::COUNT_W'(b64sc_pkg::MAX_RESULTS))
                    begin
                        res[n[b64sc_pkg::SLOT_W-1:0]] = '{out_value: b64sc_pkg::enc_char(sh[5:0]),
                            has_data: 1'b1, message_end: 1'b0, run_last: 1'b0};
                        n = n + 1'b1;
                    end
                    cm = cm + 2'd1;
                end
            end
            if (item.message_last)
            begin
                // flush leftover bits, zero-padded on the right
                if (pend != 5'd0)
                begin
                    sh = acc_n << (5'd6 - pend);
                    if (n < b64sc_pkg::COUNT_W'(b64sc_pkg::MAX_RESULTS))
                    begin
                        res[n[b64sc_pkg::SLOT_W-1:0]] = '{out_value: b64sc_pkg::enc_char(sh[5:0]),
                            has_data: 1'b1, message_end: 1'b0, run_last: 1'b0};
                        n = n + 1'b1;
                    end
                    cm = cm + 2'd1;
                end
                // pad to a multiple of four characters
                for (int k = 0; k < 3; k++)
                begin
                    if (cm != 2'd0)
                    begin
                        if (n < b64sc_pkg::COUNT_W'(b64sc_pkg::MAX_RESULTS))
                        begin
                            res[n[b64sc_pkg::SLOT_W-1:0]] = '{out_value: b64sc_pkg::CHAR_PAD,
                                has_data: 1'b1, message_end: 1'b0, run_last: 1'b0};
                            n = n + 1'b1;
                        end
                        cm = cm + 2'd1;
                    end
                end
            end
        end
        else
        begin
            cm = 2'd0;
            if (!stop)
            begin
                dch = b64sc_pkg::dec_char(item.in_value);
                if (!dch.ok)
                    stop = 1'b1;
                else
                begin
                    acc_n = {st.acc[9:0], dch.val};
                    pend  = pend + 5'd6;
                    if (pend >= 5'd8)
                    begin
                        pend = pend - 5'd8;
                        sh   = acc_n >> pend;
                        res[0] = '{out_value: sh[7:0], has_data: 1'b1,
                            message_end: 1'b0, run_last: 1'b0};
                        n = n + 1'b1;
                    end
                end
            end
        end

        // end of message: bare marker if nothing else is due, then clear state
        if (item.message_last)
        begin
            if (n == '0)
            begin
                res[0] = '0;
                n      = b64sc_pkg::COUNT_W'(1);
            end
            last_slot = b64sc_pkg::SLOT_W'(n - 1'b1);
            res[last_slot].message_end = 1'b1;
            acc_n = '0;
            pend  = '0;
            cm    = '0;
            stop  = 1'b0;
        end

        if (n != '0)
        begin
            last_slot = b64sc_pkg::SLOT_W'(n - 1'b1);
            res[last_slot].run_last = 1'b1;
        end

        grp.res   = res;
        grp.count = n;
        st_next   = '{acc: acc_n, pending: pend[3:0], cmod: cm, stopped: stop};
    end

endmodule

@@ hdl/b64sc_outq.sv @@
// Result group register that hands its results out one word per cycle while the receiver is ready.
// Depends on b64sc_pkg (result types).
module b64sc_outq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  b64sc_pkg::result_group_t grp_in,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output b64sc_pkg::out_item_t     out_data
);

    b64sc_pkg::result_group_t     grp_reg;
    logic [b64sc_pkg::SLOT_W-1:0] idx_reg;
    logic                         v_reg;
    logic                         at_last;

    assign at_last   = ({1'b0, idx_reg} + 1'b1) == grp_reg.count;
    assign free      = !v_reg || (out_ready && at_last);
    assign out_valid = v_reg;
    assign out_data  = grp_reg.res[idx_reg];

    // Group payload
    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp_in;
    end

    // Slot pointer and valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            v_reg   <= 1'b1;
            idx_reg <= '0;
        end
        else if (v_reg && out_ready)
        begin
            if (at_last)
                v_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

@@ hdl/base64_stream_codec.sv @@
// Top level of the base64 stream codec: input register, codec state, direction register.
// Depends on b64sc_pkg, b64sc_calc and b64sc_outq.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one word per byte (encode) or character
//     (decode), with message_last on the final word of a message.
//   out channel (out_valid/out_ready/out_data): result words; run_last marks the last
//     result of an input word, message_end the last of a message.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): direction, 0 encode, 1 decode; always
//     ready, write only between messages while the block is idle.
// Timing: an accepted word is registered in the input register; its whole result group
//   is then computed combinationally and loaded into the output group register once that
//   register is free, and its first result is visible from there.
// Throughput: one input word per cycle while each word gives at most one result and the
//   receiver is ready; a word with several results holds the output group register until
//   its last result is taken, and the next word waits in the input register meanwhile.
// Reset: state, direction (encode) and both valid flags clear; no clearing pass.
// Stall: a stalled receiver holds the current result; one further input word waits in
//   the input register, after which in_ready drops until the group drains.
module base64_stream_codec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  b64sc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output b64sc_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    b64sc_pkg::in_item_t      inw_reg;
    logic                     inw_v_reg;
    b64sc_pkg::codec_state_t  st_reg;
    b64sc_pkg::codec_state_t  st_next;
    b64sc_pkg::result_group_t grp;
    logic                     dir_reg;
    logic                     grp_free;
    logic                     fire;

    assign cfg_ready = 1'b1;
    assign fire      = inw_v_reg && grp_free;
    assign in_ready  = !inw_v_reg || grp_free;

    // Direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= b64sc_pkg::DIR_ENCODE;
        else if (cfg_valid && cfg_ready)
            dir_reg <= cfg_data;
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            inw_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inw_v_reg <= 1'b0;
        else if (in_valid && in_ready)
            inw_v_reg <= 1'b1;
        else if (fire)
            inw_v_reg <= 1'b0;
    end

    // Codec state, advanced as each word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (fire)
            st_reg <= st_next;
    end

    b64sc_calc u_calc (
        .dir     (dir_reg),
        .item    (inw_reg),
        .st      (st_reg),
        .st_next (st_next),
        .grp     (grp)
    );

    b64sc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && (grp.count != '0)),
        .grp_in    (grp),
        .free      (grp_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ bench/base64_stream_codec_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_codec: a directed table, then random messages in
// both directions, every result word checked against a bench predictor or a fixed table set.
// Depends on b64sc_pkg for the word types and codes, and on the RTL of the codec.
module base64_stream_codec_test;

    localparam int NUM_ROWS      = 27;
    localparam int RANDOM_WORDS  = 390;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;

    localparam logic [8*64-1:0] B64_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Direction write to make before a table row
    typedef enum logic [1:0] {STEP_KEEP, STEP_TO_ENCODE, STEP_TO_DECODE} dir_step_t;

    // Result words of one input word, first result at index 0
    typedef struct packed {
        logic [2:0]                  n;
        b64sc_pkg::out_item_t [0:3]  r;
    } result_set_t;

    // Table row: n of zero means the predictor supplies the results
    typedef struct packed {
        dir_step_t           step;
        b64sc_pkg::in_item_t word;
        result_set_t         fixed;
    } stim_row_t;

    // Bare end marker: no data, end of message, last of its word
    localparam b64sc_pkg::out_item_t [0:3] BARE_END_SET = {8'h00, 3'b011, 33'd0};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    b64sc_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    b64sc_pkg::out_item_t out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    // Predictor state, as after reset
    logic        dir_now       = b64sc_pkg::DIR_ENCODE;
    logic [15:0] acc_bits      = '0;
    int          acc_count     = 0;
    logic [1:0]  chars_in_quad = '0;
    logic        decode_halted = 1'b0;

    b64sc_pkg::out_item_t words_due [$];
    result_set_t          typed_sets [int];
    stim_row_t            stim_rows [NUM_ROWS];

    int  words_taken  = 0;
    int  words_sent   = 0;
    int  random_words = 0;
    int  mismatches   = 0;
    int  cycles_run   = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;

    base64_stream_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] alpha_char(input int idx);
        return B64_CHARS[8*(63-idx) +: 8];
    endfunction

    // Six-bit value of an alphabet character, -1 for anything else
    function automatic int sextet_code(input logic [7:0] c);
        int i;
        for (i = 0; i < 64; i++)
            if (alpha_char(i) == c)
                return i;
        return -1;
    endfunction

    function automatic b64sc_pkg::out_item_t data_word(input logic [7:0] v, input logic e,
                                                       input logic l);
        b64sc_pkg::out_item_t w;
        w.out_value   = v;
        w.has_data    = 1'b1;
        w.message_end = e;
        w.run_last    = l;
        return w;
    endfunction

    function automatic stim_row_t row_free(input dir_step_t step, input logic [7:0] v,
                                           input logic last);
        stim_row_t r;
        r.step              = step;
        r.word.in_value     = v;
        r.word.message_last = last;
        r.fixed             = '0;
        return r;
    endfunction

    function automatic stim_row_t row_typed(input dir_step_t step, input logic [7:0] v,
                                            input logic last, input logic [2:0] n,
                                            input b64sc_pkg::out_item_t [0:3] set);
        stim_row_t r;
        r         = row_free(step, v, last);
        r.fixed.n = n;
        r.fixed.r = set;
        return r;
    endfunction

    // Result words caused by one input word; advances the predictor state
    function automatic void predict_codec_words(input b64sc_pkg::in_item_t w, output int n,
                                                output b64sc_pkg::out_item_t [0:3] g);
        int s;
        n = 0;
        g = '0;
        if (dir_now == b64sc_pkg::DIR_ENCODE)
        begin
            acc_bits  = {acc_bits[7:0], w.in_value};
            acc_count += 8;
            while (acc_count >= 6)
            begin
                acc_count -= 6;
                g[n] = data_word(alpha_char((int'(acc_bits) >> acc_count) & 63),
                                 1'b0, 1'b0);
                n++;
                chars_in_quad++;
            end
            if (w.message_last)
            begin
                // flush leftover bits zero-padded, then pad to a quad
                if (acc_count > 0)
                begin
                    g[n] = data_word(alpha_char((int'(acc_bits) << (6 - acc_count)) & 63),
                                     1'b0, 1'b0);
                    n++;
                    chars_in_quad++;
                end
                while (chars_in_quad != 2'd0)
                begin
                    g[n] = data_word(b64sc_pkg::CHAR_PAD, 1'b0, 1'b0);
                    n++;
                    chars_in_quad++;
                end
            end
        end
        else
        begin
            chars_in_quad = '0;
            if (!decode_halted)
            begin
                s = sextet_code(w.in_value);
                if (s < 0)
                    decode_halted = 1'b1;
                else
                begin
                    acc_bits  = {acc_bits[9:0], s[5:0]};
                    acc_count += 6;
                    if (acc_count >= 8)
                    begin
                        acc_count -= 8;
                        g[n] = data_word(8'(int'(acc_bits) >> acc_count), 1'b0, 1'b0);
                        n++;
                    end
                end
            end
        end
        acc_count &= 15;

        // end of message: bare marker if nothing else, then clear the state
        if (w.message_last)
        begin
            if (n == 0)
            begin
                g[0] = '0;
                n    = 1;
            end
            g[n-1].message_end = 1'b1;
            acc_bits      = '0;
            acc_count     = 0;
            chars_in_quad = '0;
            decode_halted = 1'b0;
        end
        if (n > 0)
            g[n-1].run_last = 1'b1;
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input b64sc_pkg::in_item_t w);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Let every due result arrive, then allow the pipeline to settle
    task automatic drain_codec();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic d);
        drain_codec();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random message; decode messages are mostly clean base64 text
    task automatic send_message(input logic d);
        int                  len;
        int                  pads;
        int                  k;
        bit                  clean;
        logic [7:0]          c;
        b64sc_pkg::in_item_t w;
        clean  = ($urandom_range(0, 3) != 0);
        if (d == b64sc_pkg::DIR_ENCODE)
            len = $urandom_range(1, 10);
        else if (clean)
            len = 4 * $urandom_range(1, 3);
        else
            len = $urandom_range(1, 10);
        pads = (d == b64sc_pkg::DIR_DECODE && clean) ? $urandom_range(0, 2) : 0;
        for (k = 0; k < len; k++)
        begin
            if (d == b64sc_pkg::DIR_ENCODE)
                c = 8'($urandom_range(0, 255));
            else if (clean)
                c = (k >= len - pads) ? b64sc_pkg::CHAR_PAD : alpha_char($urandom_range(0, 63));
            else if ($urandom_range(0, 1) == 0)
                c = alpha_char($urandom_range(0, 63));
            else
                c = 8'($urandom_range(0, 255));
            random_words++;
            w.in_value     = c;
            w.message_last = (k == len - 1);
            send_word(w);
        end
    endtask

    // Scoreboard: predict on each accepted input word, check each result word
    always @(posedge clk)
    begin : scoreboard
        int                         n;
        int                         k;
        b64sc_pkg::out_item_t [0:3] g;
        b64sc_pkg::out_item_t       got;
        b64sc_pkg::out_item_t       want;
        cycles_run++;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                dir_now = cfg_data;
            if (in_valid && in_ready)
            begin
                predict_codec_words(in_data, n, g);
                if (typed_sets.exists(words_taken))
                begin
                    n = typed_sets[words_taken].n;
                    g = typed_sets[words_taken].r;
                end
                for (k = 0; k < n; k++)
                    words_due.insert(words_due.size(), g[k]);
                words_taken++;
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (words_due.size() == 0)
                begin
                    $display("%0t: unexpected result word value=%02h data=%b end=%b last=%b",
                             $time, got.out_value, got.has_data, got.message_end,
                             got.run_last);
                    mismatches++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (got.out_value !== want.out_value || got.has_data !== want.has_data
                        || got.message_end !== want.message_end
                        || got.run_last !== want.run_last)
                    begin
                        // fields: value/data/end/last
                        $display("%0t: mismatch: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                                 $time, want.out_value, want.has_data, want.message_end,
                                 want.run_last, got.out_value, got.has_data,
                                 got.message_end, got.run_last);
                        mismatches++;
                    end
                end
            end
        end
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink with a random stall before each word
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int i;
        int phase;
        int quota;
        logic d;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = b64sc_pkg::DIR_ENCODE;

        stim_rows = '{
            // after reset, encoding: zero byte gives AA==, all-ones byte gives /w==
            row_typed(STEP_KEEP, 8'h00, 1'b1, 3'd4,
                      {data_word("A", 1'b0, 1'b0), data_word("A", 1'b0, 1'b0),
                       data_word(b64sc_pkg::CHAR_PAD, 1'b0, 1'b0),
                       data_word(b64sc_pkg::CHAR_PAD, 1'b1, 1'b1)}),
            row_typed(STEP_KEEP, 8'hFF, 1'b1, 3'd4,
                      {data_word("/", 1'b0, 1'b0), data_word("w", 1'b0, 1'b0),
                       data_word(b64sc_pkg::CHAR_PAD, 1'b0, 1'b0),
                       data_word(b64sc_pkg::CHAR_PAD, 1'b1, 1'b1)}),
            // full quad, no padding
            row_free(STEP_KEEP, 8'h4D, 1'b0),
            row_free(STEP_KEEP, 8'h61, 1'b0),
            row_free(STEP_KEEP, 8'h6E, 1'b1),
            // decoding; first character gives no word
            row_free(STEP_TO_DECODE, "T", 1'b0),
            row_free(STEP_KEEP, "W", 1'b0),
            row_free(STEP_KEEP, "F", 1'b0),
            row_free(STEP_KEEP, "u", 1'b1),
            // pad stops the message, end comes bare
            row_free(STEP_KEEP, "/", 1'b0),
            row_free(STEP_KEEP, "w", 1'b0),
            row_typed(STEP_KEEP, b64sc_pkg::CHAR_PAD, 1'b1, 3'd1, BARE_END_SET),
            // stopped by a stray character
            row_free(STEP_KEEP, "!", 1'b0),
            row_typed(STEP_KEEP, "A", 1'b1, 3'd1, BARE_END_SET),
            // extremes outside the alphabet
            row_typed(STEP_KEEP, 8'h00, 1'b1, 3'd1, BARE_END_SET),
            row_typed(STEP_KEEP, 8'hFF, 1'b1, 3'd1, BARE_END_SET),
            // top of the lowercase and digit ranges, and the two single characters + and /
            row_free(STEP_KEEP, "+", 1'b0),
            row_free(STEP_KEEP, "/", 1'b0),
            row_free(STEP_KEEP, "9", 1'b0),
            row_free(STEP_KEEP, "z", 1'b1),
            // direction flips mid-message: bits carry over, four results from one byte
            row_free(STEP_KEEP, "Q", 1'b0),
            row_free(STEP_TO_ENCODE, 8'h41, 1'b1),
            row_free(STEP_KEEP, 8'h01, 1'b0),
            row_free(STEP_TO_DECODE, "B", 1'b0),
            row_free(STEP_KEEP, "A", 1'b1),
            // encoding carries on past a decode stop
            row_free(STEP_KEEP, "*", 1'b0),
            row_free(STEP_TO_ENCODE, 8'h80, 1'b1)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < NUM_ROWS; i++)
        begin
            if (stim_rows[i].step == STEP_TO_ENCODE)
                write_direction(b64sc_pkg::DIR_ENCODE);
            else if (stim_rows[i].step == STEP_TO_DECODE)
                write_direction(b64sc_pkg::DIR_DECODE);
            if (stim_rows[i].fixed.n != 3'd0)
                typed_sets[words_sent] = stim_rows[i].fixed;
            send_word(stim_rows[i].word);
            words_sent++;
        end

        // random phases, direction alternating, idling mode drawn per phase
        for (phase = 0; random_words < RANDOM_WORDS; phase++)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            d       = phase[0] ? b64sc_pkg::DIR_DECODE : b64sc_pkg::DIR_ENCODE;
            write_direction(d);
            quota = random_words + $urandom_range(20, 40);
            while (random_words < quota)
                send_message(d);
        end

        drain_codec();
        if (mismatches == 0 && words_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
